// ===== design/angle_bias_kalman_filter_core_macros.svh =====
// assertion macros for the angle / bias kalman filter
`ifndef ANGLE_BIAS_KALMAN_FILTER_CORE_MACROS_SVH
`define ANGLE_BIAS_KALMAN_FILTER_CORE_MACROS_SVH
// implication checked every clock outside reset
`define ABKF_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("violation");
// implication whose consequent is checked on the next clock
`define ABKF_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("violation");
`endif

// ===== design/abkf_pkg.sv =====
// package: types, constants and fixed point helpers of the kalman filter
package abkf_pkg;
  localparam int NumFilters = 4;
  localparam int FracBits = 20;
  localparam int ChW = 2;
  localparam int ChIdxW = (NumFilters > 1) ? $clog2(NumFilters) : 1;
  localparam int CfgIdxW = 2;
  localparam int CfgW = 31;
  localparam int DivCnt = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_QA = 2'd0,
    REG_QB = 2'd1,
    REG_R  = 2'd2
  } reg_idx_t;

  // datapath operations, one per sequencer step
  typedef enum logic [4:0] {
    OP_LOAD, OP_A1, OP_A2, OP_P00A, OP_P00B, OP_P00C, OP_P00D, OP_P01, OP_P10,
    OP_P11A, OP_P11B, OP_YS, OP_DIV0, OP_DIV1, OP_ANG, OP_BIAS, OP_Q00, OP_Q01,
    OP_Q10, OP_Q11, OP_STORE, OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_STEP, ST_DIVW, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic bad_ch;
  } sts_t;

  // payload of one sensor sample transaction
  typedef struct packed {
    logic [ChW-1:0]     channel;
    logic signed [31:0] accel_angle;
    logic signed [31:0] gyro_rate;
    logic [19:0]        time_step;
  } sample_t;

  // payload of one filter estimate transaction
  typedef struct packed {
    logic [ChW-1:0]     channel_out;
    logic signed [31:0] angle_estimate;
    logic signed [31:0] bias_estimate;
  } estimate_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b) + (66'sd1 <<< (FracBits - 1));
    return sat32(p >>> FracBits);
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32(66'(a) + 66'(b));
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32(66'(a) - 66'(b));
  endfunction
endpackage

// ===== design/abkf_stream_if.sv =====
// valid/ready channel carrying one filter payload
interface abkf_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/abkf_divider.sv =====
// restoring divider: (a << frac) / b truncated toward zero, saturated
module abkf_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               busy,
  output logic signed [31:0] quot
);
  logic [63:0] rem;
  logic [63:0] q;
  logic [63:0] dabs;
  logic [63:0] nabs;
  logic        neg;
  logic        zero;
  logic [6:0]  cnt;
  logic [64:0] trial;
  logic signed [65:0] sq;

  assign trial = {rem[63:0], nabs[63]} - {1'b0, dabs};
  assign sq = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 7'(abkf_pkg::DivCnt);
    end else if (busy) begin
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q <= '0;
      nabs <= (num[31] ? 64'(-66'(num)) : 64'(num)) << abkf_pkg::FracBits;
      dabs <= den[31] ? 64'(-66'(den)) : 64'(den);
      neg <= num[31] ^ den[31];
      zero <= (den == 32'sd0);
    end else if (busy) begin
      nabs <= nabs << 1;
      if (!trial[64]) begin
        rem <= trial[63:0];
        q <= {q[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], nabs[63]};
        q <= {q[62:0], 1'b0};
      end
    end
  end

  assign quot = zero ? 32'sd0 : abkf_pkg::sat32(sq);
endmodule

// ===== design/abkf_datapath.sv =====
// datapath: per channel state, one multiplier step per operation, divider
module abkf_datapath (
  input  logic                clk,
  input  logic                rst,
  input  abkf_pkg::cmd_t      cmd,
  output abkf_pkg::sts_t      sts,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [30:0]         cfg_data,
  input  logic [1:0]          in_ch,
  input  logic signed [31:0]  in_acc,
  input  logic signed [31:0]  in_rate,
  input  logic [19:0]         in_dt,
  output logic [1:0]          o_ch,
  output logic signed [31:0]  o_ang,
  output logic signed [31:0]  o_bias
);
  logic signed [31:0] st_ang [abkf_pkg::NumFilters];
  logic signed [31:0] st_bias [abkf_pkg::NumFilters];
  logic signed [31:0] st_p00 [abkf_pkg::NumFilters];
  logic signed [31:0] st_p01 [abkf_pkg::NumFilters];
  logic signed [31:0] st_p10 [abkf_pkg::NumFilters];
  logic signed [31:0] st_p11 [abkf_pkg::NumFilters];
  logic [30:0] qa, qb, rr;
  logic [1:0] ch;
  logic signed [31:0] acc, rate, dt;
  logic signed [31:0] ang, bias, p00, p01, p10, p11, y, s, k0, t;
  logic signed [31:0] ma, mb, mres;
  logic [abkf_pkg::ChIdxW-1:0] ci;
  logic div_start, div_busy;
  logic signed [31:0] div_num, quot;
  logic bad;

  assign ci = abkf_pkg::ChIdxW'(ch);
  assign bad = ({30'd0, ch} >= 32'(abkf_pkg::NumFilters));
  assign sts = '{div_busy: div_busy, bad_ch: bad};

  always_comb begin
    ma = dt;
    mb = t;
    case (cmd.op)
      abkf_pkg::OP_P00C: begin ma = $signed({1'b0, qa}); mb = dt; end
      abkf_pkg::OP_P01, abkf_pkg::OP_P10: begin ma = dt; mb = p11; end
      abkf_pkg::OP_P11A: begin ma = $signed({1'b0, qb}); mb = dt; end
      abkf_pkg::OP_ANG: begin ma = k0; mb = y; end
      abkf_pkg::OP_BIAS: begin ma = t; mb = y; end
      abkf_pkg::OP_Q00: begin ma = k0; mb = p00; end
      abkf_pkg::OP_Q01: begin ma = k0; mb = p01; end
      abkf_pkg::OP_Q10: begin ma = t; mb = p00; end
      abkf_pkg::OP_Q11: begin ma = t; mb = p01; end
      default: ;
    endcase
  end
  assign mres = abkf_pkg::fx_mul(ma, mb);

  assign div_start = cmd.start;
  assign div_num = (cmd.op == abkf_pkg::OP_DIV1) ? p10 : p00;

  abkf_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(s),
    .busy(div_busy), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      qa <= 31'd10486;
      qb <= 31'd315;
      rr <= 31'd10486;
      for (int i = 0; i < abkf_pkg::NumFilters; i++) begin
        st_ang[i] <= '0; st_bias[i] <= '0; st_p00[i] <= '0;
        st_p01[i] <= '0; st_p10[i] <= '0; st_p11[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          abkf_pkg::REG_QA: qa <= cfg_data;
          abkf_pkg::REG_QB: qb <= cfg_data;
          abkf_pkg::REG_R:  rr <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == abkf_pkg::OP_STORE && !bad) begin
        st_ang[ci] <= ang; st_bias[ci] <= bias; st_p00[ci] <= p00;
        st_p01[ci] <= p01; st_p10[ci] <= p10; st_p11[ci] <= p11;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      abkf_pkg::OP_LOAD: begin
        ch <= in_ch; acc <= in_acc; rate <= in_rate;
        dt <= $signed({12'd0, in_dt});
      end
      abkf_pkg::OP_A1: begin
        ang <= st_ang[ci]; bias <= st_bias[ci]; p00 <= st_p00[ci];
        p01 <= st_p01[ci]; p10 <= st_p10[ci]; p11 <= st_p11[ci];
        t <= abkf_pkg::fx_sub(rate, st_bias[ci]);
      end
      abkf_pkg::OP_A2: ang <= abkf_pkg::fx_add(ang, mres);
      abkf_pkg::OP_P00A: t <= abkf_pkg::fx_add(p10, p01);
      abkf_pkg::OP_P00B: p00 <= abkf_pkg::fx_sub(p00, mres);
      abkf_pkg::OP_P00C: p00 <= abkf_pkg::fx_add(p00, mres);
      abkf_pkg::OP_P00D: ;
      abkf_pkg::OP_P01: p01 <= abkf_pkg::fx_sub(p01, mres);
      abkf_pkg::OP_P10: p10 <= abkf_pkg::fx_sub(p10, mres);
      abkf_pkg::OP_P11A: p11 <= abkf_pkg::fx_add(p11, mres);
      abkf_pkg::OP_YS: begin
        y <= abkf_pkg::fx_sub(acc, ang);
        s <= abkf_pkg::fx_add(p00, $signed({1'b0, rr}));
      end
      abkf_pkg::OP_DIV1: k0 <= quot;
      abkf_pkg::OP_ANG: begin ang <= abkf_pkg::fx_add(ang, mres); t <= quot; end
      abkf_pkg::OP_BIAS: bias <= abkf_pkg::fx_add(bias, mres);
      abkf_pkg::OP_Q00: p00 <= abkf_pkg::fx_sub(p00, mres);
      abkf_pkg::OP_Q01: p01 <= abkf_pkg::fx_sub(p01, mres);
      abkf_pkg::OP_Q10: p10 <= abkf_pkg::fx_sub(p10, mres);
      abkf_pkg::OP_Q11: p11 <= abkf_pkg::fx_sub(p11, mres);
      abkf_pkg::OP_STORE: begin
        o_ch <= ch;
        o_ang <= bad ? 32'sd0 : ang;
        o_bias <= bad ? 32'sd0 : bias;
      end
      default: ;
    endcase
  end
endmodule

// ===== design/abkf_controller.sv =====
// controller: steps the datapath through predict, divide and update
module abkf_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           out_fire,
  input  abkf_pkg::sts_t sts,
  output abkf_pkg::cmd_t cmd,
  output logic           in_ready,
  output logic           out_valid
);
  abkf_pkg::state_t state, state_next;
  abkf_pkg::op_t op, op_next;
  logic start_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abkf_pkg::ST_IDLE;
      op <= abkf_pkg::OP_LOAD;
      start_pend <= 1'b0;
    end else begin
      state <= state_next;
      op <= op_next;
      start_pend <= (state_next == abkf_pkg::ST_DIVW) && (state != abkf_pkg::ST_DIVW);
    end
  end

  always_comb begin
    state_next = state;
    op_next = op;
    unique case (state)
      abkf_pkg::ST_IDLE: if (in_fire) begin
        state_next = abkf_pkg::ST_STEP; op_next = abkf_pkg::OP_A1;
      end
      abkf_pkg::ST_STEP: begin
        if (op == abkf_pkg::OP_STORE) begin
          state_next = abkf_pkg::ST_OUT;
        end else if (op == abkf_pkg::OP_A1 && sts.bad_ch) begin
          op_next = abkf_pkg::OP_STORE;
        end else if (op == abkf_pkg::OP_YS || op == abkf_pkg::OP_DIV1) begin
          state_next = abkf_pkg::ST_DIVW;
        end else begin
          op_next = abkf_pkg::op_t'(op + 5'd1);
        end
      end
      abkf_pkg::ST_DIVW: if (!start_pend && !sts.div_busy) begin
        state_next = abkf_pkg::ST_STEP;
        op_next = abkf_pkg::op_t'(op + 5'd1);
      end
      abkf_pkg::ST_OUT: if (out_fire) begin
        state_next = abkf_pkg::ST_IDLE; op_next = abkf_pkg::OP_LOAD;
      end
      default: state_next = abkf_pkg::ST_IDLE;
    endcase
  end

  // op OP_YS starts k0 divide, OP_DIV1 latches k0 and starts k1 divide
  always_comb begin
    in_ready = (state == abkf_pkg::ST_IDLE);
    out_valid = (state == abkf_pkg::ST_OUT);
    cmd.start = start_pend;
    cmd.op = abkf_pkg::OP_NONE;
    unique case (state)
      abkf_pkg::ST_IDLE: cmd.op = in_fire ? abkf_pkg::OP_LOAD : abkf_pkg::OP_NONE;
      abkf_pkg::ST_STEP: cmd.op = op;
      abkf_pkg::ST_DIVW: cmd.op = start_pend ? op : abkf_pkg::OP_NONE;
      default: cmd.op = abkf_pkg::OP_NONE;
    endcase
  end
endmodule

// ===== design/angle_bias_kalman_filter_core.sv =====
// Two-state angle / gyro bias kalman filter over four channels, Q12.20 fixed point.
// One transaction in gives one transaction out; a pass runs up to 20 sequencer
// steps through one shared 32x32 multiplier, plus two restoring divisions for the
// gains. The block takes one transaction at a time; in_ready is high only while
// idle. A channel code past the last filter changes nothing and reports zero
// estimates. Configuration writes apply at once.
module angle_bias_kalman_filter_core (
  input  logic        clk,
  input  logic        rst,
  abkf_stream_if.sink   in_s,
  abkf_stream_if.source out_s,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [30:0] cfg_data
);
  abkf_pkg::cmd_t cmd;
  abkf_pkg::sts_t sts;
  logic in_fire, out_fire;

  // transaction handshakes
  assign in_fire = in_s.valid && in_s.ready;
  assign out_fire = out_s.valid && out_s.ready;

  abkf_controller u_ctl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire), .sts(sts),
    .cmd(cmd), .in_ready(in_s.ready), .out_valid(out_s.valid)
  );

  abkf_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_s.data.channel), .in_acc(in_s.data.accel_angle),
    .in_rate(in_s.data.gyro_rate), .in_dt(in_s.data.time_step),
    .o_ch(out_s.data.channel_out), .o_ang(out_s.data.angle_estimate),
    .o_bias(out_s.data.bias_estimate)
  );
endmodule

// ===== design/abkf_checker.sv =====
// port level checks of the kalman filter core
`include "angle_bias_kalman_filter_core_macros.svh"
module abkf_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  `ABKF_ASSERT_IMP(a_no_overlap, clk, rst, out_valid, !in_ready)
  `ABKF_ASSERT_NEXT(a_busy_after_in, clk, rst, in_valid && in_ready, !in_ready)
  `ABKF_ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid)
endmodule

bind angle_bias_kalman_filter_core abkf_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_s.valid), .in_ready(in_s.ready),
  .out_valid(out_s.valid), .out_ready(out_s.ready)
);

// ===== bench/testbench.sv =====
// self-checking testbench for the four-channel angle / gyro bias kalman filter core
module testbench;
  // directed stimulus row; literal rows carry their expected estimate
  typedef struct {
    abkf_pkg::sample_t   smp;
    bit                  literal;
    abkf_pkg::estimate_t est;
  } vector_t;

  // index with no register behind it
  localparam logic [abkf_pkg::CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int WatchdogLimit = 6000;
  localparam int DrainCycles = 250;
  localparam int HoldCycles = 500;
  localparam int PhaseItems = 110;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [30:0] cfg_data = '0;

  abkf_stream_if #(.T(abkf_pkg::sample_t))   in_if ();
  abkf_stream_if #(.T(abkf_pkg::estimate_t)) out_if ();

  angle_bias_kalman_filter_core uut (
    .clk      (clk),
    .rst      (rst),
    .in_s     (in_if),
    .out_s    (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the per-channel filter state and noise settings
  logic signed [31:0] est_angle [abkf_pkg::NumFilters];
  logic signed [31:0] est_bias  [abkf_pkg::NumFilters];
  logic signed [31:0] cov00     [abkf_pkg::NumFilters];
  logic signed [31:0] cov01     [abkf_pkg::NumFilters];
  logic signed [31:0] cov10     [abkf_pkg::NumFilters];
  logic signed [31:0] cov11     [abkf_pkg::NumFilters];
  logic [30:0] angle_noise = 31'd10486;
  logic [30:0] bias_noise  = 31'd315;
  logic [30:0] meas_noise  = 31'd10486;

  abkf_pkg::estimate_t pending_estimates[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;   // stretch with back-to-back transactions on both sides
  bit  hold_req = 1'b0;  // ask the receiver for one long hold-off

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < abkf_pkg::NumFilters; i++) begin
      est_angle[i] = 0; est_bias[i] = 0;
      cov00[i] = 0; cov01[i] = 0; cov10[i] = 0; cov11[i] = 0;
    end
  end

  // fixed point arithmetic, every step saturated to 32 bits
  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< (abkf_pkg::FracBits - 1));
    // arithmetic shift floors, giving round to nearest with ties upward
    return clamp32(p >>> abkf_pkg::FracBits);
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return clamp32(64'(a) + 64'(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return clamp32(64'(a) - 64'(b));
  endfunction

  function automatic logic signed [31:0] qdiv(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] n;
    if (b == 0) return '0;  // zero innovation variance gives zero gain
    n = 64'(a) <<< abkf_pkg::FracBits;
    return clamp32(n / 64'(b));  // truncates toward zero
  endfunction

  // one predict / update pass of the selected channel
  function automatic abkf_pkg::estimate_t kalman_update(input abkf_pkg::sample_t s);
    abkf_pkg::estimate_t e;
    int ch;
    logic signed [31:0] dt, ang, bias, p00, p01, p10, p11, y, sv, k0, k1;
    ch = int'(s.channel);
    e.channel_out = s.channel;
    if (ch >= abkf_pkg::NumFilters) begin
      e.angle_estimate = '0;
      e.bias_estimate = '0;
      return e;
    end
    dt = {12'd0, s.time_step};
    ang = est_angle[ch]; bias = est_bias[ch];
    p00 = cov00[ch]; p01 = cov01[ch]; p10 = cov10[ch]; p11 = cov11[ch];
    // predict
    ang = qadd(ang, qmul(dt, qsub(s.gyro_rate, bias)));
    p00 = qsub(p00, qmul(dt, qadd(p10, p01)));
    p00 = qadd(p00, qmul($signed({1'b0, angle_noise}), dt));
    p01 = qsub(p01, qmul(dt, p11));
    p10 = qsub(p10, qmul(dt, p11));
    p11 = qadd(p11, qmul($signed({1'b0, bias_noise}), dt));
    // gains
    y = qsub(s.accel_angle, ang);
    sv = qadd(p00, $signed({1'b0, meas_noise}));
    k0 = qdiv(p00, sv);
    k1 = qdiv(p10, sv);
    // update, each covariance line sees the ones before it
    ang = qadd(ang, qmul(k0, y));
    bias = qadd(bias, qmul(k1, y));
    p00 = qsub(p00, qmul(k0, p00));
    p01 = qsub(p01, qmul(k0, p01));
    p10 = qsub(p10, qmul(k1, p00));
    p11 = qsub(p11, qmul(k1, p01));
    est_angle[ch] = ang; est_bias[ch] = bias;
    cov00[ch] = p00; cov01[ch] = p01; cov10[ch] = p10; cov11[ch] = p11;
    e.angle_estimate = ang;
    e.bias_estimate = bias;
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------
  // output side: receiver with random stalls and one long hold-off
  // ---------------------------------------------------------------------
  initial begin
    int w;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        // long stall so the core fills up and drops in_ready
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      w = no_idle ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // check every accepted estimate against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) begin
      abkf_pkg::estimate_t want;
      if (pending_estimates.size() == 0) begin
        report_mismatch("unexpected transaction, channel_out",
                        32'(out_if.data.channel_out), '0);
      end else begin
        want = pending_estimates.pop_front();
        if (out_if.data.channel_out !== want.channel_out)
          report_mismatch("channel_out", 32'(out_if.data.channel_out), 32'(want.channel_out));
        if (out_if.data.angle_estimate !== want.angle_estimate)
          report_mismatch("angle_estimate", out_if.data.angle_estimate, want.angle_estimate);
        if (out_if.data.bias_estimate !== want.bias_estimate)
          report_mismatch("bias_estimate", out_if.data.bias_estimate, want.bias_estimate);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------
  // drive one sample, wait for acceptance, record its expected estimate
  task automatic send_sample(input abkf_pkg::sample_t s, input bit literal,
                             input abkf_pkg::estimate_t lit);
    int gap;
    abkf_pkg::estimate_t e;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= s;
    do @(posedge clk); while (!in_if.ready);
    e = kalman_update(s);
    pending_estimates.push_back(literal ? lit : e);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // one write, then cfg_we drops before returning so back-to-back writes never collide
  task automatic write_reg(input logic [abkf_pkg::CfgIdxW-1:0] idx, input logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      abkf_pkg::REG_QA: angle_noise = val;
      abkf_pkg::REG_QB: bias_noise = val;
      abkf_pkg::REG_R:  meas_noise = val;
      default: ;  // unused index is ignored
    endcase
    @(posedge clk);
  endtask

  function automatic logic [30:0] pick_noise(input bit nonzero);
    case ($urandom_range(0, 5))
      0: return nonzero ? 31'd1 : 31'd0;
      1: return 31'h7fffffff;
      2: return 31'($urandom_range(1, 1 << 16));
      default: return 31'($urandom_range(1 << 8, 1 << 22));
    endcase
  endfunction

  // mostly plausible sensor data, some raw noise across the full field range
  function automatic abkf_pkg::sample_t random_sample();
    abkf_pkg::sample_t s;
    s.channel = abkf_pkg::ChW'($urandom_range(0, abkf_pkg::NumFilters - 1));
    if ($urandom_range(0, 9) < 8) begin
      s.accel_angle = 32'($signed($urandom_range(0, 180 << 20)) - (90 << 20));
      s.gyro_rate = 32'($signed($urandom_range(0, 500 << 20)) - (250 << 20));
      s.time_step = 20'($urandom_range(500, 30000));
    end else begin
      s.accel_angle = $urandom;
      s.gyro_rate = $urandom;
      s.time_step = 20'($urandom);
    end
    return s;
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      // occasional runs with no idling on either side
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_sample(random_sample(), 1'b0, '0);
    end
    no_idle = 1'b0;
  endtask

  vector_t vectors[$];

  function automatic vector_t row(input logic [1:0] ch, input logic [31:0] acc,
                                  input logic [31:0] rate, input logic [19:0] dt,
                                  input bit literal = 1'b0);
    vector_t v;
    v.smp = '{channel: ch, accel_angle: acc, gyro_rate: rate, time_step: dt};
    v.literal = literal;
    // zero time step from reset state: gains stay zero, estimates stay zero
    v.est = '{channel_out: ch, angle_estimate: '0, bias_estimate: '0};
    return v;
  endfunction

  initial begin
    // literal rows: fresh channels with zero time step report zero
    vectors.push_back(row(2'd0, 32'h7fffffff, 32'h7fffffff, 20'd0, 1'b1));
    vectors.push_back(row(2'd1, 32'h80000000, 32'h80000000, 20'd0, 1'b1));
    vectors.push_back(row(2'd2, 32'h00100000, 32'hfff00000, 20'd0, 1'b1));
    vectors.push_back(row(2'd3, 32'hffffffff, 32'h00000001, 20'd0, 1'b1));
    // field extremes, saturating paths
    vectors.push_back(row(2'd0, 32'h7fffffff, 32'h7fffffff, 20'hfffff));
    vectors.push_back(row(2'd0, 32'h80000000, 32'h80000000, 20'hfffff));
    vectors.push_back(row(2'd1, 32'h80000000, 32'h7fffffff, 20'hfffff));
    vectors.push_back(row(2'd1, 32'h7fffffff, 32'h80000000, 20'd1));
    vectors.push_back(row(2'd2, 32'h00000000, 32'h00000000, 20'd1));
    vectors.push_back(row(2'd2, 32'h05a00000, 32'h00a00000, 20'd10486));
    vectors.push_back(row(2'd3, 32'hfa600000, 32'hff600000, 20'd1048));
    vectors.push_back(row(2'd3, 32'h00000000, 32'h7fffffff, 20'h80000));
    // repeated updates so the covariance settles
    for (int i = 0; i < 8; i++)
      vectors.push_back(row(2'(i), 32'(i * 32'h00200000), 32'h00010000, 20'd10486));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (vectors[i]) send_sample(vectors[i].smp, vectors[i].literal, vectors[i].est);
    wait_drained();

    // low extremes, plus a write to the unused index
    write_reg(abkf_pkg::REG_QA, 31'd0);
    write_reg(abkf_pkg::REG_QB, 31'd0);
    write_reg(abkf_pkg::REG_R, 31'd1);
    write_reg(RegUnused, 31'h7fffffff);
    random_phase(PhaseItems);
    wait_drained();

    // high extremes, with a long receiver hold-off while samples keep coming
    write_reg(abkf_pkg::REG_QA, 31'h7fffffff);
    write_reg(abkf_pkg::REG_QB, 31'h7fffffff);
    write_reg(abkf_pkg::REG_R, 31'h7fffffff);
    hold_req = 1'b1;
    random_phase(PhaseItems);
    wait_drained();

    // sender paused above until every estimate came back; now random settings
    for (int p = 0; p < 2; p++) begin
      write_reg(abkf_pkg::REG_QA, pick_noise(1'b0));
      write_reg(abkf_pkg::REG_QB, pick_noise(1'b0));
      write_reg(abkf_pkg::REG_R, pick_noise(1'b1));
      random_phase(PhaseItems);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
